FILE: sv/sfa_pkg.sv
`timescale 1ns / 1ps
package sfa_pkg;

  localparam int HEAP_WORDS  = 65536;
  localparam int NUM_CLASSES = 8;

  // field widths
  localparam int OPC_W   = 2;
  localparam int REQ_W   = 19;
  localparam int BA_W    = 18;
  localparam int PAY_W   = 18;
  localparam int ST_W    = 2;
  localparam int CHUNK_W = 19;

  // internal byte address width, wide enough for sums of 32-bit sizes
  localparam int ADDR_W = 36;
  localparam int WAW    = $clog2(HEAP_WORDS);
  localparam int HEAP_BYTES_I = HEAP_WORDS * 4;
  localparam int BRK_W  = $clog2(HEAP_BYTES_I + 1);
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int ASZ_W  = REQ_W + 1;
  localparam int BUDGET = HEAP_WORDS / 4 + 1;
  localparam int BUD_W  = $clog2(BUDGET + 1);

  localparam logic [ADDR_W-1:0] HEAP_BYTES = ADDR_W'(HEAP_BYTES_I);
  localparam logic [ADDR_W-1:0] MIN_BLOCK  = ADDR_W'(16);
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4096);

  localparam logic [OPC_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_MALLOC = 2'd1;
  localparam logic [OPC_W-1:0] OP_FREE   = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO      = 2'd2;

  localparam int REG_CHUNK = 0;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [REQ_W-1:0] request_size;
    logic [BA_W-1:0]  block_address;
  } cmd_t;

  typedef struct packed {
    logic [PAY_W-1:0] payload_address;
    logic [ST_W-1:0]  status;
  } res_t;

  // size class: class i holds sizes below 1 << (5 + i), last class the rest
  function automatic logic [CLS_W-1:0] class_of(input logic [ADDR_W-1:0] size);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (size >= (ADDR_W'(1) << (5 + i))) c = CLS_W'(i + 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/sfa_ram.sv
`timescale 1ns / 1ps
module sfa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[addr_i] <= wdata_i;
      rdata_o <= mem[addr_i];
    end
  end

endmodule

FILE: sv/sfa_engine.sv
`timescale 1ns / 1ps
module sfa_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [sfa_pkg::CHUNK_W-1:0] chunk_i,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  sfa_pkg::cmd_t          cmd_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output sfa_pkg::res_t          res_o
);
  import sfa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
    S_GROW, S_G1, S_G2, S_G3,
    S_M0, S_M1, S_M2, S_M3, S_MP, S_MA1, S_MA2, S_MB1, S_MB2,
    S_MC1, S_MC2, S_MC3, S_MDONE,
    S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6,
    S_L0, S_L1, S_L2, S_L3,
    S_FCHK, S_FSZ, S_FNX,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_TDONE,
    S_FR0, S_FR1, S_FR2, S_DONE
  } state_e;

  state_e state_q, leaf_ret_q, merge_ret_q;

  logic [ADDR_W-1:0] heads_q [NUM_CLASSES];
  logic [BRK_W-1:0]  brk_q;
  logic [ADDR_W-1:0] bp_q, size_q, next_q, prev_q, nsize_q, old_q, tsize_q;
  logic [ADDR_W-1:0] csize_q, ub_q, lk_q, pred_q, succ_q, head_q, p_q, addr_q;
  logic [ASZ_W-1:0]  asize_q, gbytes_q;
  logic [CLS_W-1:0]  ucls_q, lcls_q, fcls_q;
  logic [BUD_W-1:0]  budget_q;
  logic              pa_q, na_q, oob_q;
  res_t              res_q;

  // memory port
  logic              mem_rd, mem_wr, inrange;
  logic [ADDR_W-1:0] mem_a;
  logic [31:0]       mem_wd, ram_rdata, rv;
  logic [ADDR_W-1:0] blk;

  assign inrange = mem_a < HEAP_BYTES;
  assign rv  = oob_q ? 32'd0 : ram_rdata;
  assign blk = ADDR_W'({rv[31:3], 3'b000});

  sfa_ram #(.DEPTH(HEAP_WORDS), .AW(WAW), .DW(32)) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_rd | (mem_wr & inrange)),
    .we_i    (mem_wr & inrange),
    .addr_i  (mem_a[WAW+1:2]),
    .wdata_i (mem_wd),
    .rdata_o (ram_rdata)
  );

  // derived values
  logic [ASZ_W-1:0]  asize_c, chunk_eff, ext_c;
  logic [ADDR_W-1:0] gsize_c, asz_a, free_end;
  logic [ASZ_W-3:0]  gwords;
  logic              split_c, free_ok;
  logic [CLS_W-1:0]  acls;
  logic [31:0]       sz32;

  always_comb begin
    asize_c   = (cmd_i.request_size <= REQ_W'(8)) ? ASZ_W'(16)
              : ((ASZ_W'(cmd_i.request_size) + ASZ_W'(15)) & ~ASZ_W'(7));
    acls      = class_of(ADDR_W'(asize_c));
    chunk_eff = (chunk_i < CHUNK_W'(16)) ? ASZ_W'(16) : ASZ_W'(chunk_i);
    ext_c     = (asize_q > chunk_eff) ? asize_q : chunk_eff;
    gwords    = gbytes_q[ASZ_W-1:2];
    gsize_c   = ADDR_W'({gwords, 2'b00}) + (gwords[0] ? ADDR_W'(4) : '0);
    asz_a     = ADDR_W'(asize_q);
    split_c   = csize_q >= asz_a + MIN_BLOCK;
    free_end  = addr_q + blk;
    free_ok   = rv[0] && (blk >= MIN_BLOCK) && (free_end <= ADDR_W'(brk_q));
    sz32      = {size_q[31:3], 3'b000};
  end

  // memory request for each step
  always_comb begin
    mem_rd = 1'b0;
    mem_wr = 1'b0;
    mem_a  = '0;
    mem_wd = '0;
    unique case (state_q)
      S_INIT0: begin mem_wr = 1'b1; mem_a = ADDR_W'(0);  mem_wd = 32'd0;  end
      S_INIT1: begin mem_wr = 1'b1; mem_a = ADDR_W'(4);  mem_wd = 32'd17; end
      S_INIT2: begin mem_wr = 1'b1; mem_a = ADDR_W'(8);  mem_wd = 32'd17; end
      S_INIT3: begin mem_wr = 1'b1; mem_a = ADDR_W'(12); mem_wd = 32'd1;  end
      S_G1: begin mem_wr = 1'b1; mem_a = bp_q - ADDR_W'(4); mem_wd = tsize_q[31:0]; end
      S_G2: begin
        mem_wr = 1'b1; mem_a = bp_q + tsize_q - ADDR_W'(8); mem_wd = tsize_q[31:0];
      end
      S_G3: begin mem_wr = 1'b1; mem_a = bp_q + tsize_q - ADDR_W'(4); mem_wd = 32'd1; end
      S_M0: begin mem_rd = 1'b1; mem_a = bp_q - ADDR_W'(4); end
      S_M1: begin mem_rd = 1'b1; mem_a = bp_q - ADDR_W'(8); end
      S_M2: begin mem_rd = 1'b1; mem_a = next_q - ADDR_W'(4); end
      S_M3: begin mem_rd = !pa_q; mem_a = prev_q - ADDR_W'(4); end
      S_MA1: begin mem_wr = 1'b1; mem_a = bp_q - ADDR_W'(4); mem_wd = sz32; end
      S_MA2: begin mem_wr = 1'b1; mem_a = bp_q + size_q - ADDR_W'(8); mem_wd = sz32; end
      S_MB1: begin mem_wr = 1'b1; mem_a = bp_q + old_q - ADDR_W'(8); mem_wd = sz32; end
      S_MB2, S_MC2: begin mem_wr = 1'b1; mem_a = prev_q - ADDR_W'(4); mem_wd = sz32; end
      S_MC3: begin
        mem_wr = 1'b1; mem_a = next_q + nsize_q - ADDR_W'(8); mem_wd = sz32;
      end
      S_U0: begin mem_rd = 1'b1; mem_a = ub_q - ADDR_W'(4); end
      S_U1: begin mem_rd = 1'b1; mem_a = ub_q; end
      S_U2: begin mem_rd = 1'b1; mem_a = ub_q + ADDR_W'(4); end
      S_U4: begin mem_wr = 1'b1; mem_a = pred_q + ADDR_W'(4); mem_wd = succ_q[31:0]; end
      S_U5: begin mem_wr = 1'b1; mem_a = succ_q; mem_wd = pred_q[31:0]; end
      S_U6: begin mem_wr = 1'b1; mem_a = succ_q; mem_wd = 32'd0; end
      S_L0: begin mem_rd = 1'b1; mem_a = lk_q - ADDR_W'(4); end
      S_L1: begin mem_wr = 1'b1; mem_a = lk_q; mem_wd = 32'd0; end
      S_L2: begin mem_wr = 1'b1; mem_a = lk_q + ADDR_W'(4); mem_wd = head_q[31:0]; end
      S_L3: begin mem_wr = 1'b1; mem_a = head_q; mem_wd = lk_q[31:0]; end
      S_FCHK: begin
        mem_rd = (p_q != '0) && (budget_q != '0); mem_a = p_q - ADDR_W'(4);
      end
      S_FSZ: begin mem_rd = 1'b1; mem_a = p_q + ADDR_W'(4); end
      S_T0: begin mem_rd = 1'b1; mem_a = bp_q - ADDR_W'(4); end
      S_T2: begin
        mem_wr = 1'b1; mem_a = bp_q - ADDR_W'(4);
        mem_wd = split_c ? (32'(asize_q) | 32'd1) : (csize_q[31:0] | 32'd1);
      end
      S_T3: begin
        mem_wr = 1'b1; mem_a = bp_q + asz_a - ADDR_W'(8); mem_wd = 32'(asize_q) | 32'd1;
      end
      S_T4: begin
        mem_wr = 1'b1; mem_a = bp_q + asz_a - ADDR_W'(4);
        mem_wd = csize_q[31:0] - 32'(asize_q);
      end
      // bp_q and csize_q already point at the remainder here
      S_T5: begin
        mem_wr = 1'b1; mem_a = bp_q + csize_q - ADDR_W'(8);
        mem_wd = csize_q[31:0];
      end
      S_T6: begin
        mem_wr = 1'b1; mem_a = bp_q + csize_q - ADDR_W'(8); mem_wd = csize_q[31:0] | 32'd1;
      end
      S_FR0: begin mem_rd = 1'b1; mem_a = addr_q - ADDR_W'(4); end
      S_FR1: begin mem_wr = free_ok; mem_a = addr_q - ADDR_W'(4); mem_wd = blk[31:0]; end
      S_FR2: begin mem_wr = 1'b1; mem_a = addr_q + size_q - ADDR_W'(8); mem_wd = sz32; end
      default: ;
    endcase
  end

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      leaf_ret_q  <= S_IDLE;
      merge_ret_q <= S_IDLE;
      for (int i = 0; i < NUM_CLASSES; i++) heads_q[i] <= '0;
      brk_q    <= '0;
      oob_q    <= 1'b0;
      bp_q     <= '0; size_q <= '0; next_q <= '0; prev_q <= '0; nsize_q <= '0;
      old_q    <= '0; tsize_q <= '0; csize_q <= '0; ub_q <= '0; lk_q <= '0;
      pred_q   <= '0; succ_q <= '0; head_q <= '0; p_q <= '0; addr_q <= '0;
      asize_q  <= '0; gbytes_q <= '0; ucls_q <= '0; lcls_q <= '0; fcls_q <= '0;
      budget_q <= '0; pa_q <= 1'b0; na_q <= 1'b0; res_q <= '0;
    end else begin
      if (mem_rd) oob_q <= !inrange;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            res_q.payload_address <= '0;
            res_q.status          <= ST_DONE;
            addr_q <= ADDR_W'(cmd_i.block_address);
            unique case (cmd_i.opcode)
              OP_INIT: state_q <= S_INIT0;
              OP_MALLOC: begin
                if (cmd_i.request_size == '0) begin
                  res_q.status <= ST_ZERO;
                  state_q      <= S_DONE;
                end else if (brk_q == '0) begin
                  res_q.status <= ST_EXHAUSTED;
                  state_q      <= S_DONE;
                end else begin
                  asize_q  <= asize_c;
                  fcls_q   <= acls;
                  p_q      <= heads_q[acls];
                  budget_q <= BUD_W'(BUDGET);
                  state_q  <= S_FCHK;
                end
              end
              OP_FREE: begin
                if (brk_q != '0 && cmd_i.block_address[2:0] == 3'b000 &&
                    cmd_i.block_address >= BA_W'(16)) state_q <= S_FR0;
                else state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_INIT0: begin
          for (int i = 0; i < NUM_CLASSES; i++) heads_q[i] <= '0;
          brk_q   <= '0;
          state_q <= S_INIT1;
        end
        S_INIT1: state_q <= S_INIT2;
        S_INIT2: state_q <= S_INIT3;
        S_INIT3: begin
          brk_q       <= BRK_W'(16);
          gbytes_q    <= chunk_eff;
          merge_ret_q <= S_DONE;
          state_q     <= S_GROW;
        end
        S_GROW: begin
          if (ADDR_W'(brk_q) + gsize_c > HEAP_BYTES) begin
            res_q.status <= ST_EXHAUSTED;
            state_q      <= S_DONE;
          end else begin
            bp_q    <= ADDR_W'(brk_q);
            tsize_q <= gsize_c;
            brk_q   <= BRK_W'(ADDR_W'(brk_q) + gsize_c);
            state_q <= S_G1;
          end
        end
        S_G1: state_q <= S_G2;
        S_G2: state_q <= S_G3;
        S_G3: state_q <= S_M0;
        // merge with free neighbors
        S_M0: state_q <= S_M1;
        S_M1: begin
          size_q  <= blk;
          next_q  <= bp_q + blk;
          state_q <= S_M2;
        end
        S_M2: begin
          prev_q  <= bp_q - blk;
          pa_q    <= rv[0];
          state_q <= S_M3;
        end
        S_M3: begin
          nsize_q <= blk;
          na_q    <= rv[0];
          if (pa_q && rv[0]) begin
            lk_q       <= bp_q;
            leaf_ret_q <= S_MDONE;
            state_q    <= S_L0;
          end else if (pa_q) begin
            size_q     <= size_q + blk;
            ub_q       <= next_q;
            leaf_ret_q <= S_MA1;
            state_q    <= S_U0;
          end else begin
            state_q <= S_MP;
          end
        end
        S_MP: begin
          if (na_q) begin
            old_q      <= size_q;
            size_q     <= size_q + blk;
            ub_q       <= prev_q;
            leaf_ret_q <= S_MB1;
          end else begin
            size_q     <= size_q + blk + nsize_q;
            ub_q       <= next_q;
            leaf_ret_q <= S_MC1;
          end
          state_q <= S_U0;
        end
        S_MA1: state_q <= S_MA2;
        S_MA2: begin
          lk_q       <= bp_q;
          leaf_ret_q <= S_MDONE;
          state_q    <= S_L0;
        end
        S_MB1: state_q <= S_MB2;
        S_MB2, S_MC3: begin
          bp_q       <= prev_q;
          lk_q       <= prev_q;
          leaf_ret_q <= S_MDONE;
          state_q    <= S_L0;
        end
        S_MC1: begin
          ub_q       <= prev_q;
          leaf_ret_q <= S_MC2;
          state_q    <= S_U0;
        end
        S_MC2: state_q <= S_MC3;
        S_MDONE: state_q <= merge_ret_q;
        // unlink ub_q from its list
        S_U0: state_q <= S_U1;
        S_U1: begin
          ucls_q  <= class_of(blk);
          state_q <= S_U2;
        end
        S_U2: begin
          pred_q  <= ADDR_W'(rv);
          state_q <= S_U3;
        end
        S_U3: begin
          succ_q <= ADDR_W'(rv);
          if (heads_q[ucls_q] != ub_q) begin
            if (pred_q != '0) state_q <= S_U4;
            else if (rv != '0) state_q <= S_U5;
            else state_q <= leaf_ret_q;
          end else begin
            heads_q[ucls_q] <= ADDR_W'(rv);
            if (rv != '0) state_q <= S_U6;
            else state_q <= leaf_ret_q;
          end
        end
        S_U4: state_q <= (succ_q != '0) ? S_U5 : leaf_ret_q;
        S_U5, S_U6: state_q <= leaf_ret_q;
        // push lk_q onto the head of its list
        S_L0: state_q <= S_L1;
        S_L1: begin
          lcls_q  <= class_of(blk);
          head_q  <= heads_q[class_of(blk)];
          state_q <= S_L2;
        end
        S_L2: begin
          heads_q[lcls_q] <= lk_q;
          state_q <= (head_q != '0) ? S_L3 : leaf_ret_q;
        end
        S_L3: state_q <= leaf_ret_q;
        // first-fit walk
        S_FCHK: begin
          if (p_q != '0 && budget_q != '0) begin
            budget_q <= budget_q - BUD_W'(1);
            state_q  <= S_FSZ;
          end else if (fcls_q == CLS_W'(NUM_CLASSES - 1)) begin
            gbytes_q    <= ext_c;
            merge_ret_q <= S_T0;
            state_q     <= S_GROW;
          end else begin
            fcls_q <= fcls_q + CLS_W'(1);
            p_q    <= heads_q[fcls_q + CLS_W'(1)];
          end
        end
        S_FSZ: begin
          if (asz_a <= blk) begin
            bp_q    <= p_q;
            state_q <= S_T0;
          end else begin
            state_q <= S_FNX;
          end
        end
        S_FNX: begin
          p_q     <= ADDR_W'(rv);
          state_q <= S_FCHK;
        end
        // place the block, split off the remainder when it is large enough
        S_T0: state_q <= S_T1;
        S_T1: begin
          csize_q    <= blk;
          ub_q       <= bp_q;
          leaf_ret_q <= S_T2;
          state_q    <= S_U0;
        end
        S_T2: state_q <= split_c ? S_T3 : S_T6;
        S_T3: state_q <= S_T4;
        S_T4: begin
          csize_q <= csize_q - asz_a;
          bp_q    <= bp_q + asz_a;
          state_q <= S_T5;
        end
        S_T5: begin
          lk_q       <= bp_q;
          bp_q       <= bp_q - asz_a;
          leaf_ret_q <= S_TDONE;
          state_q    <= S_L0;
        end
        S_T6: state_q <= S_TDONE;
        S_TDONE: begin
          res_q.payload_address <= bp_q[PAY_W-1:0];
          state_q <= S_DONE;
        end
        // release
        S_FR0: state_q <= S_FR1;
        S_FR1: begin
          size_q  <= blk;
          state_q <= free_ok ? S_FR2 : S_DONE;
        end
        S_FR2: begin
          bp_q        <= addr_q;
          merge_ret_q <= S_DONE;
          state_q     <= S_M0;
        end
        S_DONE: if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/segregated_free_list_allocator.sv
`timescale 1ns / 1ps
// from request transfer to result valid: init writes the heap header words, grows the heap by
//   a chunk and merges it; allocate passes empty classes and list nodes too small, unlinks and
//   places the fitting node and links any split-off remainder, a miss first growing the heap and
//   merging; release checks and rewrites the block, then merges; the output register comes last
// throughput: one transfer at a time, set by the single heap memory port
// reset: lists empty, heap not initialized, chunk_bytes = 4096, memory not cleared
module segregated_free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // request_size[18:0], block_address[36:19]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // payload_address[17:0]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import sfa_pkg::*;

  logic [CHUNK_W-1:0] chunk_q;
  logic               cfg_sel;
  cmd_t               cmd;
  res_t               res, out_q;
  logic               res_valid, res_ready, out_valid_q;

  // register file: one register, chunk_bytes at byte address 0
  assign cfg_sel = paddr[2] == 1'(REG_CHUNK);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? 32'(chunk_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      chunk_q <= pwdata[CHUNK_W-1:0];
    end
  end

  assign cmd.opcode        = s_axis_tuser;
  assign cmd.request_size  = s_axis_tdata[REQ_W-1:0];
  assign cmd.block_address = s_axis_tdata[REQ_W+BA_W-1:REQ_W];

  sfa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chunk_i     (chunk_q),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register on the result stream; the engine is held while it is full and downstream stalls
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 24'(out_q.payload_address);
  assign m_axis_tuser  = out_q.status;

endmodule
